### rtl/wcsr_pkg.sv
// ----------------------------------------------------------------------------
// wcsr_pkg: shared types and constants of the star pattern matcher
// Token encoding, register indexes and the control beat sent down the cells.
// ----------------------------------------------------------------------------
package wcsr_pkg;

    localparam int SYM_W           = 5;
    localparam int CFG_DATA_W      = 60;
    localparam int CFG_INDEX_W     = 2;
    localparam int STAR_W          = 24;
    localparam int CNT_W           = 5;
    localparam int TOKENS_PER_WORD = 12;

    localparam logic [SYM_W-1:0] ANY_CODE = 5'd26;

    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STAR_MASK    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKEN_COUNT  = 2'd3;

    localparam logic ACTION_CONSUME = 1'b0;
    localparam logic ACTION_FINISH  = 1'b1;

    // Control broadcast to every cell in a cycle
    typedef struct packed {
        logic             restart;
        logic             consume;
        logic [SYM_W-1:0] letter;
    } cell_ctrl_t;

endpackage

### rtl/wcsr_cell.sv
// ----------------------------------------------------------------------------
// wcsr_cell: one pattern position of the matcher chain
// Holds the pre-closure active bit of its position, closes over the starred
// token on its left and hands closure and advance bits to its right neighbor.
// ----------------------------------------------------------------------------
module wcsr_cell
    import wcsr_pkg::*;
#(
    parameter bit HEAD = 1'b0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [SYM_W-1:0] symbol,
    input  logic             star,
    input  logic             used,
    input  logic             closure_in,
    input  logic             advance_in,
    output logic             closed,
    output logic             closure_out,
    output logic             advance_out
);

    logic pre_reg;
    logic pre_next;
    logic hit;

    assign closed      = pre_reg | closure_in;
    assign hit         = closed & used & ((symbol == ANY_CODE) || (symbol == ctrl.letter));
    assign closure_out = closed & used & star;
    assign advance_out = hit & ~star;

    always_comb
    begin
        priority if (ctrl.restart)
        begin
            pre_next = HEAD;
        end
        else if (ctrl.consume)
        begin
            // stay on a starred token, or take the bit handed from the left
            pre_next = (hit & star) | advance_in;
        end
        else
        begin
            pre_next = pre_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= HEAD;
        end
        else
        begin
            pre_reg <= pre_next;
        end
    end

endmodule

### rtl/wcsr_accept.sv
// ----------------------------------------------------------------------------
// wcsr_accept: the position after the last token of the chain
// Holds the pre-closure bit of the final position of a full-length pattern.
// ----------------------------------------------------------------------------
module wcsr_accept
    import wcsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       closure_in,
    input  logic       advance_in,
    output logic       closed
);

    logic pre_reg;
    logic pre_next;

    assign closed = pre_reg | closure_in;

    always_comb
    begin
        priority if (ctrl.restart)
        begin
            pre_next = 1'b0;
        end
        else if (ctrl.consume)
        begin
            pre_next = advance_in;
        end
        else
        begin
            pre_next = pre_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= 1'b0;
        end
        else
        begin
            pre_reg <= pre_next;
        end
    end

endmodule

### rtl/wildcard_star_regex_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_star_regex_matcher_top: streaming star pattern matcher
// Letters and "any" tokens with optional star, matched by a chain of
// position cells that track the active set of the pattern automaton.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle, letters and finishes alike, while in_stall is low.
// Latency: a finish beat's result shows on out_valid the cycle after it is
//   accepted; the closure ripple through the cell chain sets the cycle time.
// Reset: pattern and result-valid registers clear to zero and the chain restarts at position zero;
//   any configuration write restarts the current string the same way.
// ----------------------------------------------------------------------------
module wildcard_star_regex_matcher_top
    import wcsr_pkg::*;
#(
    parameter int MAX_TOKENS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // input beats
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [SYM_W-1:0]       letter,

    // result beats
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   matched
);

    localparam int POS_W = $clog2(MAX_TOKENS + 1);

    // Pattern registers
    logic [CFG_DATA_W-1:0] symbols_low_reg;
    logic [CFG_DATA_W-1:0] symbols_high_reg;
    logic [STAR_W-1:0]     star_mask_reg;
    logic [CNT_W-1:0]      token_count_reg;

    logic                  cfg_write;
    logic                  in_accept;
    logic                  finish_accept;
    logic [CNT_W-1:0]      used_count;
    cell_ctrl_t            ctrl;

    // Chain wiring: entry p belongs to position p
    logic [MAX_TOKENS:0]   closed_vec;
    logic [MAX_TOKENS:0]   closure_vec;
    logic [MAX_TOKENS:0]   advance_vec;

    logic                  out_valid_reg;
    logic                  matched_reg;

    // The register port never pushes back
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    // Hold input only while a result waits and the sink stalls
    assign in_stall      = out_valid_reg & out_stall;
    assign in_accept     = in_valid & ~in_stall;
    assign finish_accept = in_accept & (action == ACTION_FINISH);

    // Clamp an oversized token count to the chain length
    assign used_count = (token_count_reg > CNT_W'(MAX_TOKENS)) ?
                        CNT_W'(MAX_TOKENS) : token_count_reg;

    // A register write or a finish both drop the string and reseed position zero
    assign ctrl.restart = cfg_write | finish_accept;
    assign ctrl.consume = in_accept & (action == ACTION_CONSUME);
    assign ctrl.letter  = letter;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
            star_mask_reg    <= '0;
            token_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                REG_STAR_MASK:    star_mask_reg    <= cfg_data[STAR_W-1:0];
                REG_TOKEN_COUNT:  token_count_reg  <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // Position zero has nothing on its left
    assign closure_vec[0] = 1'b0;
    assign advance_vec[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TOKENS; gi++)
        begin : g_cell
            logic [SYM_W-1:0] symbol;
            logic             used;

            if (gi < TOKENS_PER_WORD)
            begin : g_low
                assign symbol = symbols_low_reg[SYM_W*gi +: SYM_W];
            end
            else
            begin : g_high
                assign symbol = symbols_high_reg[SYM_W*(gi-TOKENS_PER_WORD) +: SYM_W];
            end

            assign used = (CNT_W'(gi) < used_count);

            wcsr_cell #(
                .HEAD (gi == 0)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .symbol      (symbol),
                .star        (star_mask_reg[gi]),
                .used        (used),
                .closure_in  (closure_vec[gi]),
                .advance_in  (advance_vec[gi]),
                .closed      (closed_vec[gi]),
                .closure_out (closure_vec[gi+1]),
                .advance_out (advance_vec[gi+1])
            );
        end
    endgenerate

    // Final position, reached only by a full-length pattern
    wcsr_accept u_accept (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .closure_in (closure_vec[MAX_TOKENS]),
        .advance_in (advance_vec[MAX_TOKENS]),
        .closed     (closed_vec[MAX_TOKENS])
    );

    // Result register: load on a finish beat, drop once the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The accepting position is the one just past the last used token
    always_ff @(posedge clk)
    begin
        if (finish_accept)
        begin
            matched_reg <= closed_vec[used_count[POS_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule
